/* rtl/lfb_pkg.sv */
// Shared types, constants and the digit glyph table for the LED frame buffer.
// No dependencies; every other file in rtl/ refers to it by scoped names.
`timescale 1ns / 1ps

package lfb_pkg;

   // Frame storage geometry
   localparam int FRAME_WORDS = 3;
   localparam int WORD_BITS   = 32;
   localparam int PIXELS      = FRAME_WORDS * WORD_BITS;
   localparam int WORD_IDX_W  = 2;

   // Glyph geometry and range
   localparam int GLYPH_ROWS  = 8;
   localparam int GLYPH_COLS  = 4;
   localparam logic [3:0] MAX_DIGIT = 4'd9;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Field widths
   localparam int ROW_W = 3;
   localparam int COL_W = 4;
   localparam int DIG_W = 4;

   typedef enum logic [1:0] {
      MODE_FILL   = 2'd0,
      MODE_PLOT   = 2'd1,
      MODE_GLYPH  = 2'd2,
      MODE_RENDER = 2'd3
   } mode_type;

   // One classified command, as it travels through the queue
   typedef struct packed {
      mode_type             mode;
      logic [ROW_W-1:0]     row;
      logic [COL_W-1:0]     col;
      logic                 lit;
      logic [WORD_BITS-1:0] glyph;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // 4x8 digit glyphs, row-major, MSB is the top-left pixel
   function automatic logic [WORD_BITS-1:0] glyph_bits(input logic [DIG_W-1:0] digit);
      logic [WORD_BITS-1:0] bits;
      case (digit)
         4'd0:    bits = 32'h6AAAAE00;
         4'd1:    bits = 32'h6A222200;
         4'd2:    bits = 32'h6A248E00;
         4'd3:    bits = 32'hC262AE00;
         4'd4:    bits = 32'h8AAE2200;
         4'd5:    bits = 32'hE8C2AC00;
         4'd6:    bits = 32'h68CAAE00;
         4'd7:    bits = 32'hE2488800;
         4'd8:    bits = 32'hEAEAAE00;
         4'd9:    bits = 32'hEAE2AE00;
         default: bits = '0;
      endcase
      return bits;
   endfunction

endpackage

/* rtl/lfb_front.sv */
// Front end: accepts request items, decodes the mode and looks up the glyph.
// Depends on lfb_pkg; feeds lfb_queue.
`timescale 1ns / 1ps

module lfb_front (
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [15:0]               req_tdata,   // row[2:0], col[6:3], digit[10:7], lit[11]
   input  logic [1:0]                req_tuser,   // mode[1:0]
   input  lfb_pkg::queue_status_type q_status,
   output logic                      push,
   output lfb_pkg::cmd_type          push_cmd
);

   logic [lfb_pkg::DIG_W-1:0] digit;
   logic                      drop;

   // Unpack the request fields
   always_comb begin
      digit          = req_tdata[10:7];
      push_cmd.mode  = lfb_pkg::mode_type'(req_tuser);
      push_cmd.row   = req_tdata[2:0];
      push_cmd.col   = req_tdata[6:3];
      push_cmd.lit   = req_tdata[11];
      push_cmd.glyph = lfb_pkg::glyph_bits(digit);
   end

   // Drop glyph commands with no glyph; they never change the frame
   assign drop       = (push_cmd.mode == lfb_pkg::MODE_GLYPH) && (digit > lfb_pkg::MAX_DIGIT);
   assign req_tready = !q_status.full;
   assign push       = req_tvalid && !q_status.full && !drop;

endmodule

/* rtl/lfb_queue.sv */
// Short command queue between the front end and the frame engine.
// Depends on lfb_pkg for the command type and depth.
`timescale 1ns / 1ps

module lfb_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  lfb_pkg::cmd_type          push_cmd,
   input  logic                      pop,
   output lfb_pkg::cmd_type          pop_cmd,
   output lfb_pkg::queue_status_type status
);

   localparam int DEPTH = lfb_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   lfb_pkg::cmd_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // Advance pointers with wrap, track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed item
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign pop_cmd      = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

/* rtl/lfb_back.sv */
// Frame engine: holds the packed frame, applies drawing commands, streams renders.
// Depends on lfb_pkg; takes commands from lfb_queue.
`timescale 1ns / 1ps

module lfb_back #(
   parameter int ROWS = 8,
   parameter int COLS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   input  lfb_pkg::cmd_type      cmd,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [31:0]           rsp_tdata,   // frame_word[31:0]
   output logic [1:0]            rsp_tuser,   // word_index[1:0]
   output logic                  rsp_tlast
);

   localparam int WORDS = lfb_pkg::FRAME_WORDS;
   localparam int WB    = lfb_pkg::WORD_BITS;
   localparam int IW    = lfb_pkg::WORD_IDX_W;
   localparam logic [IW-1:0] LAST_WORD = IW'(WORDS - 1);

   logic [WORDS-1:0][WB-1:0] frame_ff, frame_in;
   logic [WORDS-1:0][WB-1:0] draw_frame;
   logic [IW-1:0]            word_cnt_ff, word_cnt_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [WB-1:0]            rsp_word_ff, rsp_word_in;
   logic [IW-1:0]            rsp_index_ff, rsp_index_in;
   logic                     rsp_last_ff, rsp_last_in;
   logic                     out_free;

   // Per-pixel hit test for plot and glyph; each frame bit has a fixed (row, col)
   for (genvar i = 0; i < lfb_pkg::PIXELS; i++) begin : g_pix
      localparam int PR = i / COLS;
      localparam int PC = i % COLS;
      localparam int WI = i / WB;
      localparam int BI = WB - 1 - (i % WB);
      logic touch;
      if (PR < ROWS) begin : g_on
         logic [5:0] dr;
         logic [4:0] dc;
         logic       plot_hit;
         logic       glyph_hit;
         assign dr = 6'(PR) - 6'(cmd.row);
         assign dc = 5'(PC) - 5'(cmd.col);
         if (PR < 8) begin : g_row_ok
            assign plot_hit = (cmd.row == 3'(PR)) && (cmd.col == 4'(PC));
         end else begin : g_row_far
            assign plot_hit = 1'b0;
         end
         // glyph bit 31-(dr*4+dc) is the complement of the 5-bit index
         assign glyph_hit = (dr[5:3] == 3'd0) && (dc[4:2] == 3'd0)
                            && cmd.glyph[~{dr[2:0], dc[1:0]}];
         assign touch = (cmd.mode == lfb_pkg::MODE_PLOT) ? plot_hit : glyph_hit;
      end else begin : g_off
         assign touch = 1'b0;
      end
      assign draw_frame[WI][BI] = touch ? cmd.lit : frame_ff[WI][BI];
   end

   // Output register takes a new word when empty or drained this cycle
   assign out_free = !rsp_valid_ff || rsp_tready;

   // Execute the head command
   always_comb begin
      frame_in     = frame_ff;
      word_cnt_in  = word_cnt_ff;
      pop          = 1'b0;
      rsp_valid_in = out_free ? 1'b0 : rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_index_in = rsp_index_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd_valid) begin
         unique case (cmd.mode)
            lfb_pkg::MODE_FILL: begin
               frame_in = {(WORDS * WB){cmd.lit}};
               pop      = 1'b1;
            end
            lfb_pkg::MODE_PLOT, lfb_pkg::MODE_GLYPH: begin
               frame_in = draw_frame;
               pop      = 1'b1;
            end
            lfb_pkg::MODE_RENDER: begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_word_in  = frame_ff[word_cnt_ff];
                  rsp_index_in = word_cnt_ff;
                  rsp_last_in  = (word_cnt_ff == LAST_WORD);
                  if (word_cnt_ff == LAST_WORD) begin
                     word_cnt_in = '0;
                     pop         = 1'b1;
                  end else begin
                     word_cnt_in = word_cnt_ff + 1'b1;
                  end
               end
            end
            default: begin
               pop = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff     <= '0;
         word_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         frame_ff     <= frame_in;
         word_cnt_ff  <= word_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output payload needs no reset
   always_ff @(posedge clock) begin
      rsp_word_ff  <= rsp_word_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_word_ff;
   assign rsp_tuser  = rsp_index_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* rtl/led_frame_buffer_glyph_blit.sv */
// Top level of the LED frame buffer with digit glyph blit.
// Depends on lfb_pkg, lfb_front, lfb_queue and lfb_back.
`timescale 1ns / 1ps

// A packed monochrome frame of ROWS x COLS pixels lives in three 32-bit words;
// pixel row*COLS+col sits at bit 31-(index mod 32) of word index/32. Request
// items are taken in one per cycle while the two-entry command queue has room.
// The frame engine retires a fill, plot or glyph command as one masked update
// of all 96 bits and a render command as three words, one word per cycle,
// each held in the output register until rsp_tready takes it; render
// throughput is set by that output register. Glyph commands with a digit
// above 9 are dropped at the front and never reach the queue. Result items
// appear only for render: words 0, 1, 2, tlast on the final one.

module led_frame_buffer_glyph_blit #(
   parameter int ROWS = 8,
   parameter int COLS = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // row[2:0], col[6:3], digit[10:7], lit[11]
   input  logic [1:0]  req_tuser,   // mode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // frame_word[31:0]
   output logic [1:0]  rsp_tuser,   // word_index[1:0]
   output logic        rsp_tlast
);

   lfb_pkg::queue_status_type q_status;
   lfb_pkg::cmd_type          push_cmd;
   lfb_pkg::cmd_type          head_cmd;
   logic                      push;
   logic                      pop;

   lfb_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_status   (q_status),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   lfb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (head_cmd),
      .status   (q_status)
   );

   lfb_back #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (!q_status.empty),
      .cmd        (head_cmd),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // tlast marks exactly the final frame word
   a_last_word : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser == 2'd2)))
      else $error("tlast does not match final word index");

   // word index never names a fourth word
   a_index_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser != 2'd3))
      else $error("word index out of range");

   // queue never reports full and empty together
   a_queue_level : assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue full and empty at once");

   // a pop only ever takes a stored command
   a_pop_nonempty : assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("pop from empty queue");

endmodule

/* tb/sv/tb_led_frame_buffer_glyph_blit.sv */
// Self-checking bench for the LED frame buffer with digit glyph blit.
// Depends on lfb_pkg and led_frame_buffer_glyph_blit; keeps its own frame model.
`timescale 1ns / 1ps

module tb_led_frame_buffer_glyph_blit;

   localparam int ROWS        = 8;
   localparam int COLS        = 12;
   localparam int RANDOM_CMDS = 500;
   localparam int CYCLE_LIMIT = 200000;
   localparam int TAIL_CYCLES = 16;
   localparam int LONG_HOLD   = 300;
   localparam int HOLD_AT     = 60;

   // Own copy of the digit font, row-major, MSB is the top-left pixel
   localparam logic [31:0] DIGIT_FONT [10] = '{
      32'h6AAAAE00, 32'h6A222200, 32'h6A248E00, 32'hC262AE00, 32'h8AAE2200,
      32'hE8C2AC00, 32'h68CAAE00, 32'hE2488800, 32'hEAEAAE00, 32'hEAE2AE00
   };

   typedef struct packed {
      lfb_pkg::mode_type mode;
      logic [2:0]        row;
      logic [3:0]        col;
      logic [3:0]        digit;
      logic              lit;
   } blit_cmd_type;

   // One directed row; frame holds word 0 in its top 32 bits when typed is set
   typedef struct packed {
      blit_cmd_type cmd;
      logic         typed;
      logic [95:0]  frame;
   } directed_row_type;

   typedef struct packed {
      logic [31:0] word;
      logic [1:0]  index;
      logic        last;
   } frame_word_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // row[2:0], col[6:3], digit[10:7], lit[11]
   logic [1:0]  req_tuser;   // mode[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // frame_word[31:0]
   logic [1:0]  rsp_tuser;   // word_index[1:0]
   logic        rsp_tlast;

   logic [31:0]      frame_model [lfb_pkg::FRAME_WORDS];
   frame_word_type   word_queue [$];
   directed_row_type directed_rows [$];

   int  error_count   = 0;
   int  cycle_count   = 0;
   int  words_checked = 0;
   int  renders_sent  = 0;
   int  glyphs_sent   = 0;
   int  cmds_sent     = 0;
   int  long_holds    = 0;
   bit  calm          = 1'b0;

   led_frame_buffer_glyph_blit #(.ROWS(ROWS), .COLS(COLS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #2 clock = ~clock;

   // Abort on a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still expected",
                  cycle_count, word_queue.size());
         $display("tb_led_frame_buffer_glyph_blit: FAIL");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at cycle %0d: %s got %h expected %h",
               cycle_count, what, got, want);
      error_count++;
   endtask

   function automatic void set_pixel(input int r, input int c, input logic on);
      int idx;
      if (r >= ROWS || c >= COLS) return;
      idx = r * COLS + c;
      if (idx >= lfb_pkg::FRAME_WORDS * 32) return;
      frame_model[idx / 32][31 - (idx % 32)] = on;
   endfunction

   // Update the frame model for one accepted item; queue words on render
   task automatic apply_command(input blit_cmd_type c, input logic typed,
                                input logic [95:0] frame);
      logic [31:0]    font;
      frame_word_type w;
      case (c.mode)
         lfb_pkg::MODE_FILL: begin
            for (int i = 0; i < lfb_pkg::FRAME_WORDS; i++) frame_model[i] = {32{c.lit}};
         end
         lfb_pkg::MODE_PLOT: begin
            set_pixel(int'(c.row), int'(c.col), c.lit);
         end
         lfb_pkg::MODE_GLYPH: begin
            glyphs_sent++;
            if (c.digit <= lfb_pkg::MAX_DIGIT) begin
               font = DIGIT_FONT[c.digit];
               for (int dr = 0; dr < lfb_pkg::GLYPH_ROWS; dr++)
                  for (int dc = 0; dc < lfb_pkg::GLYPH_COLS; dc++)
                     if (font[31 - (dr * lfb_pkg::GLYPH_COLS + dc)])
                        set_pixel(int'(c.row) + dr, int'(c.col) + dc, c.lit);
            end
         end
         default: begin
            renders_sent++;
            for (int i = 0; i < lfb_pkg::FRAME_WORDS; i++) begin
               w.word  = typed ? frame[95 - 32 * i -: 32] : frame_model[i];
               w.index = 2'(i);
               w.last  = (i == lfb_pkg::FRAME_WORDS - 1);
               word_queue.push_back(w);
            end
         end
      endcase
   endtask

   // Offer one item after a random gap, none in calm phases, and hold it until accepted
   task automatic send_command(input blit_cmd_type c, input logic typed,
                               input logic [95:0] frame);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, c.lit, c.digit, c.col, c.row};
      req_tuser  <= c.mode;
      do @(posedge clock); while (!req_tready);
      apply_command(c, typed, frame);
      cmds_sent++;
   endtask

   task automatic add_row(input lfb_pkg::mode_type m, input int r, input int c,
                          input int d, input logic on, input logic typed,
                          input logic [95:0] frame);
      directed_row_type e;
      e.cmd.mode  = m;
      e.cmd.row   = 3'(r);
      e.cmd.col   = 4'(c);
      e.cmd.digit = 4'(d);
      e.cmd.lit   = on;
      e.typed     = typed;
      e.frame     = frame;
      directed_rows.push_back(e);
   endtask

   // Mostly well-formed random commands with some out-of-frame columns and bad digits
   function automatic blit_cmd_type random_command();
      blit_cmd_type c;
      int pick;
      pick    = $urandom_range(0, 99);
      c.mode  = pick < 8 ? lfb_pkg::MODE_FILL : pick < 40 ? lfb_pkg::MODE_PLOT :
                pick < 78 ? lfb_pkg::MODE_GLYPH : lfb_pkg::MODE_RENDER;
      c.row   = 3'($urandom_range(0, 7));
      c.col   = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, 11))
                                             : 4'($urandom_range(12, 15));
      c.digit = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, 9))
                                             : 4'($urandom_range(10, 15));
      c.lit   = (c.mode == lfb_pkg::MODE_FILL) ? ($urandom_range(0, 99) < 30)
                                               : 1'($urandom_range(0, 1));
      return c;
   endfunction

   // Result side: random back-pressure, one long hold while items keep coming
   initial begin
      int gap;
      frame_word_type w;
      rsp_tready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         gap = calm ? 0 : $urandom_range(0, 6);
         if (words_checked == HOLD_AT) begin
            gap = LONG_HOLD;
            long_holds++;
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         words_checked++;
         if (word_queue.size() == 0) begin
            report_mismatch("result with nothing expected, frame_word", rsp_tdata, 32'h0);
         end else begin
            w = word_queue.pop_front();
            if (rsp_tdata !== w.word) report_mismatch("frame_word", rsp_tdata, w.word);
            if (rsp_tuser !== w.index)
               report_mismatch("word_index", 32'(rsp_tuser), 32'(w.index));
            if (rsp_tlast !== w.last)
               report_mismatch("last", 32'(rsp_tlast), 32'(w.last));
         end
      end
   end

   // Reset, directed table, random commands, drain and verdict
   initial begin
      blit_cmd_type c;
      clock        = 1'b0;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = lfb_pkg::MODE_FILL;
      for (int i = 0; i < lfb_pkg::FRAME_WORDS; i++) frame_model[i] = '0;

      // Frame after reset, fills, corner pixels, clipping and bad digits
      add_row(lfb_pkg::MODE_RENDER, 0, 0, 0, 0, 1, 96'h0);
      add_row(lfb_pkg::MODE_FILL,   7, 15, 15, 1, 0, 96'h0);
      add_row(lfb_pkg::MODE_RENDER, 0, 0, 0, 0, 1, {96{1'b1}});
      add_row(lfb_pkg::MODE_FILL,   0, 0, 0, 0, 0, 96'h0);
      add_row(lfb_pkg::MODE_PLOT,   0, 0, 0, 1, 0, 96'h0);
      add_row(lfb_pkg::MODE_PLOT,   7, 11, 0, 1, 0, 96'h0);
      add_row(lfb_pkg::MODE_RENDER, 0, 0, 0, 0, 1,
              {32'h80000000, 32'h0, 32'h00000001});
      add_row(lfb_pkg::MODE_PLOT,   7, 12, 0, 1, 0, 96'h0);
      add_row(lfb_pkg::MODE_PLOT,   3, 15, 0, 1, 0, 96'h0);
      add_row(lfb_pkg::MODE_GLYPH,  0, 0, 10, 1, 0, 96'h0);
      add_row(lfb_pkg::MODE_GLYPH,  2, 2, 15, 1, 0, 96'h0);
      add_row(lfb_pkg::MODE_RENDER, 0, 0, 0, 0, 1,
              {32'h80000000, 32'h0, 32'h00000001});
      add_row(lfb_pkg::MODE_GLYPH,  0, 0, 8, 1, 0, 96'h0);
      add_row(lfb_pkg::MODE_GLYPH,  7, 11, 9, 1, 0, 96'h0);
      add_row(lfb_pkg::MODE_GLYPH,  4, 10, 0, 1, 0, 96'h0);
      add_row(lfb_pkg::MODE_RENDER, 0, 0, 0, 0, 0, 96'h0);
      add_row(lfb_pkg::MODE_FILL,   0, 0, 0, 1, 0, 96'h0);
      add_row(lfb_pkg::MODE_GLYPH,  0, 4, 1, 0, 0, 96'h0);
      add_row(lfb_pkg::MODE_GLYPH,  3, 8, 7, 0, 0, 96'h0);
      add_row(lfb_pkg::MODE_PLOT,   5, 5, 0, 0, 0, 96'h0);
      add_row(lfb_pkg::MODE_RENDER, 0, 0, 0, 0, 0, 96'h0);
      add_row(lfb_pkg::MODE_FILL,   0, 0, 0, 0, 0, 96'h0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_command(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].frame);

      for (int i = 0; i < RANDOM_CMDS; i++) begin
         calm = ((i / 60) % 4) == 3;
         // Pause until every queued word has come out
         if (i == 300) begin
            req_tvalid <= 1'b0;
            while (word_queue.size() > 0) @(posedge clock);
            repeat (TAIL_CYCLES) @(posedge clock);
         end
         c = random_command();
         send_command(c, 1'b0, 96'h0);
      end
      req_tvalid <= 1'b0;

      while (word_queue.size() > 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d items: %0d renders, %0d glyph blits, %0d words checked",
               cmds_sent, renders_sent, glyphs_sent, words_checked);
      $display("long result holds: %0d, mismatches: %0d", long_holds, error_count);
      if (error_count == 0) begin
         $display("tb_led_frame_buffer_glyph_blit: PASS");
      end else begin
         $display("tb_led_frame_buffer_glyph_blit: FAIL");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/lfb_pkg.sv
rtl/lfb_front.sv
rtl/lfb_queue.sv
rtl/lfb_back.sv
rtl/led_frame_buffer_glyph_blit.sv
tb/sv/tb_led_frame_buffer_glyph_blit.sv
